@@ hw/rtl/mdps_pkg.sv @@
package mdps_pkg;

    localparam int MAX_ADDR_DEF      = 32;
    localparam int SLOTS_PER_ROW_DEF = 4;
    localparam int ROW_COUNT         = 7;

    localparam int MODE_W  = 3;
    localparam int ADDR_W  = 8;
    localparam int INDEX_W = 5;
    localparam int POLL_W  = 6;
    localparam int COUNT_W = 6;
    localparam int RES_W   = 10;

    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PRESENT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ABSENT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NEXT    = 3'd5;

    // Tick period of each schedule row
    function automatic int row_period(input int row);
        int p;
        p = 1;
        case (row)
            0: p = 1;
            1: p = 2;
            2: p = 6;
            3: p = 12;
            4: p = 60;
            5: p = 120;
            6: p = 600;
            default: p = 1;
        endcase
        return p;
    endfunction

    typedef struct packed {
        logic update;
        logic tick_start;
        logic row_next;
        logic walk_adv;
        logic emit;
        logic tick_done;
        logic search_start;
        logic search_step;
        logic flush;
    } mdps_cmd_t;

    typedef struct packed {
        logic row_due;
        logic row_end;
        logic entry_ok;
        logic entry_present;
        logic col_last;
        logic out_free;
        logic pend_valid;
        logic count_zero;
        logic pos_present;
    } mdps_stat_t;

endpackage

@@ hw/rtl/mdps_in_if.sv @@
interface mdps_in_if import mdps_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [ADDR_W-1:0]  device_addr;
    logic [INDEX_W-1:0] slot_index;
    logic [ADDR_W-1:0]  slot_value;

    modport source (output valid, output mode, output device_addr, output slot_index,
                    output slot_value, input ready);
    modport sink (input valid, input mode, input device_addr, input slot_index,
                  input slot_value, output ready);
endinterface

@@ hw/rtl/mdps_out_if.sv @@
interface mdps_out_if import mdps_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [POLL_W-1:0]  poll_addr;
    logic               found;
    logic               last;
    logic [COUNT_W-1:0] device_count;
    logic               error;

    modport source (output valid, output poll_addr, output found, output last,
                    output device_count, output error, input ready);
    modport sink (input valid, input poll_addr, input found, input last,
                  input device_count, input error, output ready);
endinterface

@@ hw/rtl/mdps_ram.sv @@
module mdps_ram import mdps_pkg::*; #(
    parameter int WIDTH = ADDR_W,
    parameter int DEPTH = ROW_COUNT * SLOTS_PER_ROW_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/mdps_ctrl.sv @@
module mdps_ctrl import mdps_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [MODE_W-1:0] mode,
    output logic              in_ready,
    input  mdps_stat_t        stat,
    output mdps_cmd_t         cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ROW    = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode)
                        MODE_TICK:
                        begin
                            cmd.tick_start = 1'b1;
                            state_next     = S_ROW;
                        end
                        MODE_PRESENT, MODE_ABSENT, MODE_WRITE, MODE_CLEAR:
                        begin
                            cmd.update = 1'b1;
                            state_next = S_FLUSH;
                        end
                        MODE_NEXT:
                        begin
                            cmd.search_start = 1'b1;
                            state_next       = stat.count_zero ? S_FLUSH : S_SEARCH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ROW:
            begin
                if (stat.row_end)
                begin
                    cmd.tick_done = 1'b1;
                    state_next    = S_FLUSH;
                end
                else if (stat.row_due)
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    cmd.row_next = 1'b1;
                end
            end
            S_WALK:
            begin
                if (!stat.entry_ok)
                begin
                    cmd.row_next = 1'b1;
                    state_next   = S_ROW;
                end
                else if (!(stat.entry_present && stat.pend_valid && !stat.out_free))
                begin
                    cmd.emit = stat.entry_present;
                    if (stat.col_last)
                    begin
                        cmd.row_next = 1'b1;
                        state_next   = S_ROW;
                    end
                    else
                    begin
                        cmd.walk_adv = 1'b1;
                    end
                end
            end
            S_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (stat.pos_present)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/mdps_datapath.sv @@
module mdps_datapath import mdps_pkg::*; #(
    parameter int MAX_ADDR      = MAX_ADDR_DEF,
    parameter int SLOTS_PER_ROW = SLOTS_PER_ROW_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mdps_cmd_t          cmd,
    output mdps_stat_t         stat,
    input  logic [MODE_W-1:0]  mode,
    input  logic [ADDR_W-1:0]  device_addr,
    input  logic [INDEX_W-1:0] slot_index,
    input  logic [ADDR_W-1:0]  slot_value,
    mdps_out_if.source         response
);

    localparam int TABLE_SIZE = ROW_COUNT * SLOTS_PER_ROW;
    localparam int AW         = $clog2(TABLE_SIZE);
    localparam int SW         = AW + 1;
    localparam int CW         = $clog2(SLOTS_PER_ROW + 1);
    localparam int AB         = $clog2(MAX_ADDR + 1);
    localparam int IXW        = AW + INDEX_W;

    logic [MAX_ADDR:0]    map_reg, map_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [AB-1:0]        cursor_reg, cursor_next;
    logic [AB-1:0]        pos_reg, pos_next;
    logic [TABLE_SIZE-1:0] tv_reg, tv_next;
    logic                 vq_reg;
    logic [2:0]           row_reg, row_next;
    logic [CW-1:0]        col_reg, col_next;

    logic                 pend_valid_reg, pend_valid_next;
    logic [POLL_W-1:0]    pend_addr_reg, pend_addr_next;
    logic                 pend_found_reg, pend_found_next;
    logic                 pend_err_reg, pend_err_next;

    logic                 out_valid_reg, out_valid_next;
    logic [POLL_W-1:0]    out_addr_reg, out_addr_next;
    logic                 out_found_reg, out_found_next;
    logic                 out_last_reg, out_last_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;
    logic                 out_err_reg, out_err_next;

    logic [RES_W-1:0]     res_reg [ROW_COUNT];
    logic [7:0]           due_vec;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;
    logic [ADDR_W-1:0]    ram_rdata;
    logic [SW-1:0]        slot_sum;
    logic [IXW-1:0]       idx_ext;
    logic                 idx_ok;
    logic                 dev_ok;
    logic [AB-1:0]        dev_idx;
    logic [ADDR_W-1:0]    entry;
    logic                 entry_ok;
    logic                 entry_present;
    logic [AB-1:0]        pos_inc;
    logic                 out_free;

    // Per-row tick residues stand in for the divisibility checks
    generate
        for (genvar r = 0; r < ROW_COUNT; r++)
        begin : g_res
            localparam int PERIOD = row_period(r);
            localparam logic [RES_W-1:0] RELOAD = RES_W'(2 % PERIOD);
            localparam logic [RES_W-1:0] TOP    = RES_W'(PERIOD - 1);
            logic [RES_W-1:0] res_next;

            always_comb
            begin
                res_next = res_reg[r];
                if (cmd.tick_done)
                begin
                    if (res_reg[ROW_COUNT-1] == '0)
                    begin
                        res_next = RELOAD;
                    end
                    else if (res_reg[r] == TOP)
                    begin
                        res_next = '0;
                    end
                    else
                    begin
                        res_next = res_reg[r] + 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    res_reg[r] <= '0;
                end
                else
                begin
                    res_reg[r] <= res_next;
                end
            end

            assign due_vec[r] = (res_reg[r] == '0);
        end
        for (genvar r = ROW_COUNT; r < 8; r++)
        begin : g_nodue
            assign due_vec[r] = 1'b0;
        end
    endgenerate

    assign idx_ext   = IXW'(slot_index);
    assign idx_ok    = (idx_ext < IXW'(TABLE_SIZE));
    assign ram_waddr = idx_ext[AW-1:0];
    assign ram_we    = cmd.update && (mode == MODE_WRITE) && idx_ok;

    assign dev_ok  = (device_addr != '0) && (device_addr <= ADDR_W'(MAX_ADDR));
    assign dev_idx = device_addr[AB-1:0];

    // Read address: current slot, or the next one when the walk advances
    assign slot_sum  = SW'(row_reg) * SW'(SLOTS_PER_ROW) + SW'(col_reg) + SW'(cmd.walk_adv);
    assign ram_raddr = (slot_sum < SW'(TABLE_SIZE)) ? slot_sum[AW-1:0] : '0;

    mdps_ram #(
        .WIDTH(ADDR_W),
        .DEPTH(TABLE_SIZE)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(slot_value),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign entry         = vq_reg ? ram_rdata : '0;
    assign entry_ok      = (entry != '0) && (entry <= ADDR_W'(MAX_ADDR));
    assign entry_present = entry_ok && map_reg[entry[AB-1:0]];
    assign pos_inc       = (pos_reg == AB'(MAX_ADDR)) ? '0 : pos_reg + 1'b1;
    assign out_free      = !out_valid_reg || response.ready;

    always_comb
    begin
        stat               = '0;
        stat.row_due       = due_vec[row_reg];
        stat.row_end       = (row_reg == 3'(ROW_COUNT));
        stat.entry_ok      = entry_ok;
        stat.entry_present = entry_present;
        stat.col_last      = (col_reg == CW'(SLOTS_PER_ROW - 1));
        stat.out_free      = out_free;
        stat.pend_valid    = pend_valid_reg;
        stat.count_zero    = (count_reg == '0);
        stat.pos_present   = map_reg[pos_reg];
    end

    always_comb
    begin
        map_next        = map_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        pos_next        = pos_reg;
        tv_next         = tv_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        pend_found_next = pend_found_reg;
        pend_err_next   = pend_err_reg;
        out_valid_next  = out_valid_reg && !response.ready;
        out_addr_next   = out_addr_reg;
        out_found_next  = out_found_reg;
        out_last_next   = out_last_reg;
        out_count_next  = out_count_reg;
        out_err_next    = out_err_reg;

        if (cmd.update)
        begin
            pend_valid_next = 1'b1;
            pend_addr_next  = '0;
            pend_found_next = 1'b0;
            pend_err_next   = 1'b0;
            case (mode)
                MODE_PRESENT:
                begin
                    pend_err_next = !dev_ok;
                    if (dev_ok && !map_reg[dev_idx])
                    begin
                        map_next[dev_idx] = 1'b1;
                        count_next        = count_reg + 1'b1;
                    end
                end
                MODE_ABSENT:
                begin
                    pend_err_next = !dev_ok;
                    if (dev_ok && map_reg[dev_idx])
                    begin
                        map_next[dev_idx] = 1'b0;
                        count_next        = count_reg - 1'b1;
                    end
                end
                MODE_WRITE:
                begin
                    pend_err_next = !idx_ok;
                    if (idx_ok)
                    begin
                        tv_next[ram_waddr] = 1'b1;
                    end
                end
                MODE_CLEAR:
                begin
                    tv_next = '0;
                end
                default:
                begin
                    pend_err_next = 1'b0;
                end
            endcase
        end

        if (cmd.tick_start)
        begin
            row_next = '0;
            col_next = '0;
        end
        if (cmd.row_next)
        begin
            row_next = row_reg + 1'b1;
            col_next = '0;
        end
        if (cmd.walk_adv)
        begin
            col_next = col_reg + 1'b1;
        end

        // Hold one result back so the final one can carry last
        if (cmd.emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_addr_next  = pend_addr_reg;
                out_found_next = pend_found_reg;
                out_last_next  = 1'b0;
                out_count_next = count_reg;
                out_err_next   = pend_err_reg;
            end
            pend_valid_next = 1'b1;
            pend_addr_next  = entry[POLL_W-1:0];
            pend_found_next = 1'b1;
            pend_err_next   = 1'b0;
        end

        if (cmd.search_start)
        begin
            pos_next = (cursor_reg > AB'(MAX_ADDR)) ? '0 : cursor_reg;
            if (count_reg == '0)
            begin
                pend_valid_next = 1'b1;
                pend_addr_next  = '0;
                pend_found_next = 1'b0;
                pend_err_next   = 1'b0;
            end
        end
        if (cmd.search_step)
        begin
            if (map_reg[pos_reg])
            begin
                pend_valid_next = 1'b1;
                pend_addr_next  = POLL_W'(pos_reg);
                pend_found_next = 1'b1;
                pend_err_next   = 1'b0;
                cursor_next     = pos_inc;
            end
            else
            begin
                pos_next = pos_inc;
            end
        end

        if (cmd.flush)
        begin
            out_valid_next  = 1'b1;
            out_addr_next   = pend_addr_reg;
            out_found_next  = pend_found_reg;
            out_last_next   = 1'b1;
            out_count_next  = count_reg;
            out_err_next    = pend_err_reg;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg        <= '0;
            count_reg      <= '0;
            cursor_reg     <= '0;
            tv_reg         <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            map_reg        <= map_next;
            count_reg      <= count_next;
            cursor_reg     <= cursor_next;
            tv_reg         <= tv_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vq_reg         <= tv_reg[ram_raddr];
        pos_reg        <= pos_next;
        pend_addr_reg  <= pend_addr_next;
        pend_found_reg <= pend_found_next;
        pend_err_reg   <= pend_err_next;
        out_addr_reg   <= out_addr_next;
        out_found_reg  <= out_found_next;
        out_last_reg   <= out_last_next;
        out_count_reg  <= out_count_next;
        out_err_reg    <= out_err_next;
    end

    assign response.valid        = out_valid_reg;
    assign response.poll_addr    = out_addr_reg;
    assign response.found        = out_found_reg;
    assign response.last         = out_last_reg;
    assign response.device_count = out_count_reg;
    assign response.error        = out_err_reg;

endmodule

@@ hw/rtl/multirate_device_poll_scheduler_core.sv @@
// Channel    Direction  Payload                                          Transfer
// request    in         mode, device_addr, slot_index, slot_value        valid & ready
// response   out        poll_addr, found, last, device_count, error      valid & ready
//
// Flow: one item at a time. A tick walks the due rows through the single read
// port of the schedule RAM, one slot per cycle unless a full response register
// stalls the walk. A next-present query tests at most MAX_ADDR + 1 presence bits,
// one per cycle.
// Reset: rst_n clears the presence map, count, cursor, tick residues and the
// per-slot valid bits, so the schedule reads as empty at once; no clearing pass.
// Stalls: a full response register stalls the slot walk; the request side is ready
// only while no item is in progress.
module multirate_device_poll_scheduler_core import mdps_pkg::*; #(
    parameter int MAX_ADDR      = MAX_ADDR_DEF,
    parameter int SLOTS_PER_ROW = SLOTS_PER_ROW_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mdps_in_if.sink    request,
    mdps_out_if.source response
);

    mdps_cmd_t  cmd;
    mdps_stat_t stat;
    logic       in_ready;

    // Sequencer: decode the transfer mode and step the walk or the search
    mdps_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(request.valid),
        .mode    (request.mode),
        .in_ready(in_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    assign request.ready = in_ready;

    // State, schedule RAM, held result and response register
    mdps_datapath #(
        .MAX_ADDR     (MAX_ADDR),
        .SLOTS_PER_ROW(SLOTS_PER_ROW)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .mode       (request.mode),
        .device_addr(request.device_addr),
        .slot_index (request.slot_index),
        .slot_value (request.slot_value),
        .response   (response)
    );

endmodule

@@ bench/tb.sv @@
module tb;
    import mdps_pkg::*;

    // Predictor dimensions follow the block's default build
    localparam int MAX_A   = MAX_ADDR_DEF;
    localparam int SLOTS   = SLOTS_PER_ROW_DEF;
    localparam int TABLE_N = ROW_COUNT * SLOTS;

    // Modes the block has no use for; it must swallow them without a response
    localparam logic [MODE_W-1:0] MODE_UNDEF_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNDEF_HI = 3'd7;

    // Watchdog: the slowest legal run is well under a quarter of this
    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int unsigned TAIL_CYCLES  = 64;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [ADDR_W-1:0]  device_addr;
        logic [INDEX_W-1:0] slot_index;
        logic [ADDR_W-1:0]  slot_value;
    } poll_req_t;

    typedef struct packed {
        logic [POLL_W-1:0]  poll_addr;
        logic               found;
        logic               last;
        logic [COUNT_W-1:0] device_count;
        logic               error;
    } poll_resp_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mdps_in_if  request_ch ();
    mdps_out_if response_ch ();

    multirate_device_poll_scheduler_core #(
        .MAX_ADDR      (MAX_ADDR_DEF),
        .SLOTS_PER_ROW (SLOTS_PER_ROW_DEF)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    // Bench-side copies of the drive signals, known from time zero
    logic      drv_valid  = 1'b0;
    poll_req_t drv_req    = '0;
    logic      resp_ready = 1'b0;
    logic      hold_off   = 1'b0;

    assign request_ch.valid       = drv_valid;
    assign request_ch.mode        = drv_req.mode;
    assign request_ch.device_addr = drv_req.device_addr;
    assign request_ch.slot_index  = drv_req.slot_index;
    assign request_ch.slot_value  = drv_req.slot_value;
    assign response_ch.ready      = resp_ready;

    // Free-running clock: 6 high, 6 low
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: shadow of the scheduler's map, cursor and schedule
    // ------------------------------------------------------------------
    logic [MAX_A:0]     present_map;
    logic [COUNT_W-1:0] present_cnt;
    int unsigned        rr_pos;
    logic [9:0]         tick_cnt;
    logic [ADDR_W-1:0]  slot_tbl [TABLE_N];
    int unsigned        row_tick_div [ROW_COUNT] = '{1, 2, 6, 12, 60, 120, 600};

    poll_req_t  request_backlog [$];   // items not yet offered to the block
    poll_resp_t awaited_resp_q [$];    // responses the block still owes us

    int unsigned fail_count     = 0;
    int unsigned items_accepted = 0;
    int unsigned resp_checked   = 0;
    int unsigned ticks_polled   = 0;
    int unsigned peak_burst     = 0;
    int unsigned counter_wraps  = 0;

    // Work out every response one accepted item causes and queue them in order
    function automatic void forecast_responses(input poll_req_t rq);
        poll_resp_t  r;
        poll_resp_t  tick_list [$];
        int unsigned a;
        int unsigned pos;
        int unsigned dev;
        int          row;
        int          col;
        int          i;
        bit          hit;
        r   = '0;
        dev = rq.device_addr;
        case (rq.mode)
            MODE_TICK:
            begin
                for (row = 0; row < ROW_COUNT; row++)
                begin
                    if (tick_cnt % row_tick_div[row] == 0)
                    begin
                        // Walk the due row; an empty or out-of-range slot ends it
                        for (col = 0; col < SLOTS; col++)
                        begin
                            a = slot_tbl[row * SLOTS + col];
                            if (a < 1 || a > MAX_A)
                                break;
                            if (present_map[a])
                            begin
                                r.poll_addr    = POLL_W'(a);
                                r.found        = 1'b1;
                                r.last         = 1'b0;
                                r.device_count = present_cnt;
                                r.error        = 1'b0;
                                tick_list.push_back(r);
                            end
                        end
                    end
                end
                if (tick_list.size() > 0)
                begin
                    tick_list[tick_list.size() - 1].last = 1'b1;
                    ticks_polled++;
                    if (tick_list.size() > peak_burst)
                        peak_burst = tick_list.size();
                end
                foreach (tick_list[k])
                    awaited_resp_q.push_back(tick_list[k]);
                // The slowest row's period resets the counter to 2
                if (tick_cnt % row_tick_div[ROW_COUNT - 1] == 0)
                begin
                    tick_cnt = 10'd2;
                    counter_wraps++;
                end
                else
                    tick_cnt = tick_cnt + 10'd1;
            end
            MODE_PRESENT, MODE_ABSENT:
            begin
                if (dev < 1 || dev > MAX_A)
                    r.error = 1'b1;
                else if (rq.mode == MODE_PRESENT && !present_map[dev])
                begin
                    present_map[dev] = 1'b1;
                    present_cnt      = present_cnt + 1'b1;
                end
                else if (rq.mode == MODE_ABSENT && present_map[dev])
                begin
                    present_map[dev] = 1'b0;
                    present_cnt      = present_cnt - 1'b1;
                end
                r.last         = 1'b1;
                r.device_count = present_cnt;
                awaited_resp_q.push_back(r);
            end
            MODE_WRITE:
            begin
                if (rq.slot_index >= TABLE_N)
                    r.error = 1'b1;
                else
                    slot_tbl[rq.slot_index] = rq.slot_value;
                r.last         = 1'b1;
                r.device_count = present_cnt;
                awaited_resp_q.push_back(r);
            end
            MODE_CLEAR:
            begin
                for (i = 0; i < TABLE_N; i++)
                    slot_tbl[i] = '0;
                r.last         = 1'b1;
                r.device_count = present_cnt;
                awaited_resp_q.push_back(r);
            end
            MODE_NEXT:
            begin
                // Round-robin search from the cursor, wrapping past the top address
                pos = (rr_pos > MAX_A) ? 0 : rr_pos;
                hit = 1'b0;
                for (i = 0; i <= MAX_A && !hit; i++)
                begin
                    if (present_map[pos])
                    begin
                        hit         = 1'b1;
                        rr_pos      = (pos + 1 > MAX_A) ? 0 : pos + 1;
                        r.poll_addr = POLL_W'(pos);
                        r.found     = 1'b1;
                    end
                    else
                        pos = (pos + 1 > MAX_A) ? 0 : pos + 1;
                end
                r.last         = 1'b1;
                r.device_count = present_cnt;
                awaited_resp_q.push_back(r);
            end
            default:
            begin
                // Undefined mode: no response, no state change
            end
        endcase
    endfunction

    function automatic void queue_req(input logic [MODE_W-1:0] m, input int unsigned dev,
                                      input int unsigned idx, input int unsigned val);
        poll_req_t rq;
        rq.mode        = m;
        rq.device_addr = ADDR_W'(dev);
        rq.slot_index  = INDEX_W'(idx);
        rq.slot_value  = ADDR_W'(val);
        request_backlog.push_back(rq);
    endfunction

    // Mostly legal traffic with random content; a small share of bad codes and noise
    function automatic poll_req_t random_req();
        poll_req_t   rq;
        int unsigned pick;
        rq.mode        = MODE_TICK;
        rq.device_addr = ADDR_W'($urandom_range(0, 255));
        rq.slot_index  = INDEX_W'($urandom_range(0, 31));
        rq.slot_value  = ADDR_W'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 30)
            rq.mode = MODE_TICK;
        else if (pick < 55)
        begin
            rq.mode = (pick < 45) ? MODE_PRESENT : MODE_ABSENT;
            if ($urandom_range(0, 9) != 0)
                rq.device_addr = ADDR_W'($urandom_range(1, MAX_A));
        end
        else if (pick < 77)
        begin
            rq.mode       = MODE_WRITE;
            rq.slot_index = ($urandom_range(0, 9) == 0) ? INDEX_W'($urandom_range(TABLE_N, 31))
                                                        : INDEX_W'($urandom_range(0, TABLE_N - 1));
            if ($urandom_range(0, 5) != 0)
                rq.slot_value = ADDR_W'($urandom_range(1, MAX_A));
        end
        else if (pick < 80)
            rq.mode = MODE_CLEAR;
        else if (pick < 94)
            rq.mode = MODE_NEXT;
        else
            rq.mode = ($urandom_range(0, 1) == 0) ? MODE_UNDEF_LO : MODE_UNDEF_HI;
        return rq;
    endfunction

    task automatic check_field(input string fname, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v)
        begin
            $error("response field %s: expected %0d, actual %0d", fname, exp_v, got_v);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offer backlog items in bursts of random length, separated
    // by random gaps. Hold an offered item until its transfer completes.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid  <= 1'b0;
            drv_req    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            // Predict at the transfer, from the payload the block just took
            if (drv_valid && request_ch.ready)
            begin
                forecast_responses(drv_req);
                items_accepted++;
            end
            if (drv_valid && !request_ch.ready)
            begin
                // Hold: the block has not taken the item yet
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                drv_valid <= 1'b0;
            end
            else if (request_backlog.size() > 0)
            begin
                drv_req   <= request_backlog.pop_front();
                drv_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    // Start a new burst; a quarter of them follow with no gap at all
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
            else
                drv_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare every response transfer against the oldest
    // outstanding prediction. Ready follows a randomly drawn stall style,
    // and drops for the whole long hold-off.
    // ------------------------------------------------------------------
    int unsigned stall_cycle = 0;
    int unsigned stall_style = 0;

    always @(posedge clk or negedge rst_n)
    begin
        poll_resp_t want;
        logic       next_ready;
        if (!rst_n)
        begin
            resp_ready  <= 1'b0;
            stall_cycle = 0;
            stall_style = 0;
        end
        else
        begin
            if (response_ch.valid && resp_ready)
            begin
                if (awaited_resp_q.size() == 0)
                begin
                    $error("response with nothing outstanding: poll_addr %0d found %0d",
                           response_ch.poll_addr, response_ch.found);
                    fail_count++;
                end
                else
                begin
                    want = awaited_resp_q.pop_front();
                    check_field("poll_addr", want.poll_addr, response_ch.poll_addr);
                    check_field("found", want.found, response_ch.found);
                    check_field("last", want.last, response_ch.last);
                    check_field("device_count", want.device_count, response_ch.device_count);
                    check_field("error", want.error, response_ch.error);
                    resp_checked++;
                end
            end
            stall_cycle++;
            if (stall_cycle % 97 == 0)
                stall_style = $urandom_range(0, 3);
            case (stall_style)
                0: next_ready = 1'b1;
                1: next_ready = ($urandom_range(0, 1) == 0);
                2: next_ready = (stall_cycle % 4 == 0);
                default: next_ready = ($urandom_range(0, 7) != 0);
            endcase
            resp_ready <= hold_off ? 1'b0 : next_ready;
        end
    end

    // Long receiver hold-off: the sender keeps offering, so the block backs up
    initial
    begin
        @(posedge rst_n);
        repeat (250) @(posedge clk);
        hold_off <= 1'b1;
        repeat (600) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog
    initial
    begin
        #(64'd12 * LIMIT_CYCLES);
        $display("multirate_device_poll_scheduler_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        present_map = '0;
        present_cnt = '0;
        rr_pos      = 0;
        tick_cnt    = '0;
        for (i = 0; i < TABLE_N; i++)
            slot_tbl[i] = '0;

        // Directed: bad addresses, empty-map query, repeats, bad slot indexes
        queue_req(MODE_PRESENT, 0, $urandom, $urandom);
        queue_req(MODE_PRESENT, MAX_A + 1, $urandom, $urandom);
        queue_req(MODE_ABSENT, 255, $urandom, $urandom);
        queue_req(MODE_NEXT, $urandom, $urandom, $urandom);
        queue_req(MODE_PRESENT, 1, $urandom, $urandom);
        queue_req(MODE_PRESENT, MAX_A, $urandom, $urandom);
        queue_req(MODE_PRESENT, 1, $urandom, $urandom);
        queue_req(MODE_ABSENT, 7, $urandom, $urandom);
        queue_req(MODE_WRITE, $urandom, TABLE_N, 1);
        queue_req(MODE_WRITE, $urandom, 31, 1);
        // Row 0: 1, top address, then an empty slot that hides the slot behind it
        queue_req(MODE_WRITE, $urandom, 0, 1);
        queue_req(MODE_WRITE, $urandom, 1, MAX_A);
        queue_req(MODE_WRITE, $urandom, 2, 0);
        queue_req(MODE_WRITE, $urandom, 3, 1);
        // Row 1 ends at once on an address past the top
        queue_req(MODE_WRITE, $urandom, 4, MAX_A + 1);
        // Row 6 full: an absent device in the middle is skipped, not a stop
        queue_req(MODE_WRITE, $urandom, 24, MAX_A);
        queue_req(MODE_WRITE, $urandom, 25, 1);
        queue_req(MODE_WRITE, $urandom, 26, 5);
        queue_req(MODE_WRITE, $urandom, TABLE_N - 1, 255);
        // First tick sees a zero counter, so every row is due
        queue_req(MODE_TICK, $urandom, $urandom, $urandom);
        queue_req(MODE_TICK, $urandom, $urandom, $urandom);
        // Cursor walk wraps from the top address back to 1
        for (i = 0; i < 3; i++)
            queue_req(MODE_NEXT, $urandom, $urandom, $urandom);
        queue_req(MODE_UNDEF_LO, $urandom, $urandom, $urandom);
        queue_req(MODE_UNDEF_HI, $urandom, $urandom, $urandom);
        queue_req(MODE_CLEAR, $urandom, $urandom, $urandom);
        queue_req(MODE_TICK, $urandom, $urandom, $urandom);

        // Long tick run: fill every device and the slow rows, then tick far
        // enough that the 2, 6, 12 and 60 periods all come due
        for (i = 1; i <= MAX_A; i++)
            queue_req(MODE_PRESENT, i, $urandom, $urandom);
        for (i = 0; i < 8; i++)
            queue_req(MODE_ABSENT, $urandom_range(1, MAX_A), $urandom, $urandom);
        for (i = 4 * SLOTS; i < TABLE_N; i++)
            queue_req(MODE_WRITE, $urandom, i,
                      ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, MAX_A));
        for (i = 0; i < 60; i++)
            queue_req(MODE_TICK, $urandom, $urandom, $urandom);

        // Random traffic
        for (i = 0; i < 80; i++)
            request_backlog.push_back(random_req());

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Drain: everything offered, nothing outstanding, then wait out an idle tail
        while (request_backlog.size() > 0 || drv_valid || awaited_resp_q.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (awaited_resp_q.size() > 0)
        begin
            $error("%0d predicted responses never arrived", awaited_resp_q.size());
            fail_count++;
        end
        $display("run summary: %0d requests transferred, %0d responses compared",
                 items_accepted, resp_checked);
        $display("  %0d ticks polled devices (longest burst %0d), %0d tick counter wraps",
                 ticks_polled, peak_burst, counter_wraps);
        if (fail_count == 0)
            $display("multirate_device_poll_scheduler_core: match");
        else
            $display("multirate_device_poll_scheduler_core: mismatch");
        $finish;
    end

endmodule
